// File: rtl/core/spr_pkg.sv
package spr_pkg;

    // Fixed sizes of the block
    localparam int HEADER_BYTES = 2;
    localparam int BUFFER_BYTES = 512;

    // Store address, and a position that can also hold the store size itself
    localparam int BUF_AW = $clog2(BUFFER_BYTES);
    localparam int POS_W  = $clog2(BUFFER_BYTES + 1);
    // Width of the length-plus-fill sum used by the overflow check
    localparam int SUM_W  = ((POS_W > 8) ? POS_W : 8) + 1;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_PAYLOAD_SIZE = '0;
    localparam logic [7:0] PAYLOAD_SIZE_RESET = 8'd20;

    // Command codes
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Packet kinds
    localparam logic [1:0] KIND_UNSPLIT = 2'd0;
    localparam logic [1:0] KIND_INTER   = 2'd1;
    localparam logic [1:0] KIND_FINAL   = 2'd2;

    // Status codes
    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_UNSPLIT   = 3'd1;
    localparam logic [2:0] ST_COMPLETE  = 3'd2;
    localparam logic [2:0] ST_TOO_BIG   = 3'd3;
    localparam logic [2:0] ST_MISSING   = 3'd4;
    localparam logic [2:0] ST_SHORT     = 3'd5;
    localparam logic [2:0] ST_DISCARDED = 3'd6;

    typedef struct packed {
        logic       cmd;
        logic [1:0] kind;
        logic [7:0] split_index;
        logic [7:0] packet_length;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [8:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] message_length;
        logic [7:0] read_data;
    } out_item_t;

    // Store write request
    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    // Store read request
    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
    } store_rd_t;

    // Result handed from the control logic to the output register
    typedef struct packed {
        logic [2:0] status;
        logic [9:0] message_length;
        logic       read_hit;
    } result_t;

endpackage

// File: rtl/core/spr_in_stage.sv
module spr_in_stage
    import spr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    input  logic     ready,
    output logic     fire,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign fire     = valid_reg & ready;
    assign in_stall = valid_reg & ~ready;
    assign item     = item_reg;

    // Refill whenever the held word moves on or the register is empty
    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_data;
        end
    end

endmodule

// File: rtl/core/spr_store.sv
module spr_store
    import spr_pkg::*;
(
    input  logic      clk,
    input  store_wr_t wr,
    input  store_rd_t rd,
    output logic [7:0] rdata
);

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Hold the last read until the next read command
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/spr_ctrl.sv
module spr_ctrl
    import spr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  in_item_t   item,
    input  logic [7:0] payload_size,
    output store_wr_t  wr,
    output store_rd_t  rd,
    output result_t    res
);

    logic [POS_W-1:0] fill_reg, fill_next;
    logic [POS_W-1:0] wp_reg, wp_next;
    logic             miss_reg, miss_next;
    logic             acc_reg, acc_next;
    logic [2:0]       pend_reg, pend_next;

    logic [7:0]       step;
    logic [15:0]      dest;
    logic [POS_W-1:0] fill_eff;
    logic [SUM_W-1:0] len_sum;
    logic             too_big;
    logic [7:0]       pay;

    // Per-split step and destination; these need only the held word and the register
    assign step = (payload_size > 8'(HEADER_BYTES)) ? payload_size - 8'(HEADER_BYTES) : 8'd0;
    assign dest = 16'(item.split_index) * 16'(step);
    assign pay  = item.packet_length - 8'(HEADER_BYTES);

    always_comb
    begin
        fill_next = fill_reg;
        wp_next   = wp_reg;
        miss_next = miss_reg;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        fill_eff  = fill_reg;
        len_sum   = '0;
        too_big   = 1'b0;
        wr        = '0;
        rd        = '0;
        res       = '0;

        if (item.cmd == CMD_READ)
        begin
            res.read_hit = (32'(item.read_index) < BUFFER_BYTES);
            rd.en        = fire & res.read_hit;
            rd.addr      = BUF_AW'(item.read_index);
        end
        else
        begin
            if (item.first_byte)
            begin
                acc_next = 1'b0;
                if (!(item.kind inside {KIND_INTER, KIND_FINAL}))
                begin
                    miss_next = 1'b0;
                    pend_next = ST_UNSPLIT;
                end
                else
                begin
                    // Index zero starts a new message
                    if (item.split_index == 8'd0)
                    begin
                        fill_eff  = '0;
                        miss_next = 1'b0;
                    end
                    fill_next = fill_eff;
                    len_sum   = SUM_W'(item.packet_length) + SUM_W'(fill_eff);
                    too_big   = (item.packet_length < 8'(HEADER_BYTES))
                              || (len_sum > SUM_W'(BUFFER_BYTES + HEADER_BYTES));
                    if (too_big)
                    begin
                        fill_next = '0;
                        miss_next = 1'b1;
                        pend_next = ST_TOO_BIG;
                    end
                    else if (16'(fill_eff) < dest)
                    begin
                        fill_next = '0;
                        miss_next = 1'b1;
                        pend_next = ST_MISSING;
                    end
                    else if (item.kind == KIND_INTER && item.packet_length != payload_size)
                    begin
                        fill_next = '0;
                        miss_next = 1'b1;
                        pend_next = ST_SHORT;
                    end
                    else
                    begin
                        wp_next   = POS_W'(dest);
                        fill_next = fill_eff + POS_W'(pay);
                        acc_next  = 1'b1;
                        pend_next = (item.kind == KIND_FINAL) ? ST_COMPLETE : ST_BUSY;
                    end
                end
            end

            // Store the byte of an accepted packet while room remains
            if (acc_next && (32'(wp_next) < BUFFER_BYTES))
            begin
                wr.en   = fire;
                wr.addr = BUF_AW'(wp_next);
                wr.data = item.data_byte;
                wp_next = wp_next + POS_W'(1);
            end

            if (item.last_byte)
            begin
                if (acc_next && pend_next == ST_COMPLETE)
                begin
                    if (miss_next)
                    begin
                        miss_next  = 1'b0;
                        res.status = ST_DISCARDED;
                    end
                    else
                    begin
                        res.status         = ST_COMPLETE;
                        res.message_length = 10'(fill_next);
                    end
                    fill_next = '0;
                end
                else
                begin
                    res.status = pend_next;
                end
                pend_next = ST_BUSY;
                acc_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            wp_reg   <= '0;
            miss_reg <= 1'b0;
            acc_reg  <= 1'b0;
            pend_reg <= ST_BUSY;
        end
        else if (fire)
        begin
            fill_reg <= fill_next;
            wp_reg   <= wp_next;
            miss_reg <= miss_next;
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Fill position stays within the store
    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= BUFFER_BYTES)
        else $error("fill position beyond store");

    // Write pointer stops at the end of the store
    a_wp_bound : assert property (@(posedge clk) disable iff (!rst_n)
        32'(wp_reg) <= BUFFER_BYTES)
        else $error("write pointer beyond store");

    // Store traffic only for a word that moves on, and never both ways at once
    a_store_fire : assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en || rd.en) |-> (fire && !(wr.en && rd.en)))
        else $error("store access without an advancing word");

    // Only a complete report carries a message length
    a_len_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (res.status != ST_COMPLETE) |-> (res.message_length == 10'd0))
        else $error("message length without completion");
`endif

endmodule

// File: rtl/core/spr_out_stage.sv
module spr_out_stage
    import spr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  result_t    res,
    input  logic [7:0] rdata,
    output logic       ready,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Take a new result when empty or when the held one leaves this cycle
    assign ready = ~valid_reg | ~out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
        begin
            valid_next = fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid               = valid_reg;
    assign out_data.status         = res_reg.status;
    assign out_data.message_length = res_reg.message_length;
    assign out_data.read_data      = res_reg.read_hit ? rdata : 8'd0;

endmodule

// File: rtl/core/split_packet_reassembler_unit.sv
// Split packet reassembler.
// Input channel (in_valid / in_stall / in_data): one word per payload byte of a
// link packet, split header already removed, or one read command for a byte of
// the reassembly store. The first byte of a packet carries its kind, split index
// and length; the packet is checked once, on that byte, and accepted bytes land
// at split_index * (payload_size - HEADER_BYTES) onward.
// Output channel (out_valid / out_stall / out_data): exactly one result word per
// input word, in order: busy, or on a last byte the packet's outcome, or the
// stored byte for a read.
// A word accepted by the input sits in the input register while the checks, state
// update and store access settle in one pass into the result register, which drives
// out_valid. Throughput is one word per cycle while the output is not stalled; each
// word makes at most one access to the 512-byte store.
// A stall on the output holds the result and, one word later, stalls the input;
// words are never lost or repeated.
// Reset clears all reassembly state and sets payload_size to 20; the store holds no
// reset value and needs no clearing pass. payload_size is written over the APB port
// at word address 0; the user writes it only while the block is idle (not enforced).
module split_packet_reassembler_unit
    import spr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic       cfg_write;
    logic [7:0] payload_size_reg;
    logic [7:0] payload_size_next;
    logic       cfg_hit;

    logic       ready;
    logic       fire;
    in_item_t   item;
    store_wr_t  wr;
    store_rd_t  rd;
    result_t    res;
    logic [7:0] rdata;

    // Register decode: word address taken from the upper address bits
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[ADDR_W-1:2] == REG_PAYLOAD_SIZE);
    assign cfg_write = psel & penable & pwrite & pready & cfg_hit;

    always_comb
    begin
        payload_size_next = payload_size_reg;
        if (cfg_write)
        begin
            payload_size_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_size_reg <= PAYLOAD_SIZE_RESET;
        end
        else
        begin
            payload_size_reg <= payload_size_next;
        end
    end

    // Read back the register; unmapped addresses read as zero
    assign prdata = cfg_hit ? DATA_W'(payload_size_reg) : '0;

    // Input register: hold the next word while the current one waits
    spr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .ready    (ready),
        .fire     (fire),
        .item     (item)
    );

    // Packet checks and reassembly state, one pass per word
    spr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (item),
        .payload_size (payload_size_reg),
        .wr           (wr),
        .rd           (rd),
        .res          (res)
    );

    // Reassembly store: one write or one registered read per cycle
    spr_store u_store (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    // Result register: hold the word while the receiver stalls
    spr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .rdata     (rdata),
        .ready     (ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
